>>> design/qac_pkg.sv
// Shared types and constants for the quadratic assignment cost evaluator.
// No dependencies; used by the top level by scoped names.
package qac_pkg;

    localparam int unsigned DATA_W    = 16;
    localparam int unsigned COST_W    = 44;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCATION_COUNT = 2'd1;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_FLOW = 2'd0,
        ACT_DIST = 2'd1,
        ACT_LOC  = 2'd2,
        ACT_EVAL = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CHECK_WAIT,
        ST_SUM,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

>>> design/qac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qac_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/quadratic_assignment_cost.sv
// Quadratic assignment cost evaluator: flow/distance/mapping stores and cost sequencer.
// Depends on qac_pkg and qac_ram.
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+----------------------------
//  in      | in_valid, in_stall              | sink      | action, row, col, value
//  out     | out_valid, out_stall            | source    | cost, bad_mapping
//  cfg     | cfg_valid, cfg_ready            | sink      | cfg_index, cfg_data
//
// Loads are taken one per cycle while in_stall is low. After an evaluate is accepted, a
// mapping check pass of zc reads (zc = zones in use) and a decision state come first,
// then one zone pair per cycle through the flow RAM read port, a drain of the multiply
// pipeline and the post of the result. A bad mapping posts straight from the decision state,
// and with no zones in use from idle; a result still held by out_stall delays the post.
// in_stall is high from an evaluate until its result is in the output register;
// loads are still taken while a result waits on out_stall. Stores have no reset and
// need no clearing pass; control state resets asynchronously on rst_n.
module quadratic_assignment_cost #(
    parameter int unsigned MAX_ZONES     = 64,
    parameter int unsigned MAX_LOCATIONS = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [5:0]  row,
    input  logic [5:0]  col,
    input  logic [15:0] value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [43:0] cost,
    output logic        bad_mapping,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int unsigned ZIW   = $clog2(MAX_ZONES);
    localparam int unsigned ZCW   = $clog2(MAX_ZONES + 1);
    localparam int unsigned LIW   = $clog2(MAX_LOCATIONS);
    localparam int unsigned LCW   = $clog2(MAX_LOCATIONS + 1);
    localparam int unsigned LW    = $clog2(MAX_LOCATIONS + 2);
    localparam int unsigned FAW   = $clog2(MAX_ZONES * MAX_ZONES);
    localparam int unsigned DAW   = $clog2(MAX_LOCATIONS * MAX_LOCATIONS);
    localparam int unsigned ZCMPW = (ZCW > qac_pkg::COUNT_W) ? ZCW : qac_pkg::COUNT_W;
    localparam int unsigned LCMPW = (LCW > qac_pkg::COUNT_W) ? LCW : qac_pkg::COUNT_W;
    localparam int unsigned RNGW  = 9;
    localparam int unsigned VALW  = qac_pkg::DATA_W + 1;

    qac_pkg::state_t state_reg, state_next;

    logic [ZIW-1:0] i_reg, i_next;
    logic [ZIW-1:0] j_reg, j_next;
    logic           p_reg;
    logic           bad_reg;
    logic           s1_v_reg, s2_v_reg, s3_v_reg;
    logic [qac_pkg::DATA_W-1:0] f_reg;
    logic [qac_pkg::PROD_W-1:0] prod_reg;
    logic [qac_pkg::COST_W-1:0] acc_reg;
    logic                       out_valid_reg;
    logic [qac_pkg::COST_W-1:0] cost_reg;
    logic                       bad_out_reg;
    logic [qac_pkg::COUNT_W-1:0] zone_count_reg, location_count_reg;

    qac_pkg::action_t act;
    logic in_acc, eval_start;
    logic row_ok_z, col_ok_z, row_ok_l, col_ok_l;
    logic flow_we, dist_we, loc_we;
    logic [FAW-1:0] flow_waddr, flow_raddr;
    logic [DAW-1:0] dist_waddr, dist_raddr;
    logic [ZIW-1:0] loc_waddr;
    logic [LW-1:0]  loc_wdata;
    logic [qac_pkg::DATA_W-1:0] flow_rdata, dist_rdata;
    logic [LW-1:0]  loca_rdata, locb_rdata;
    logic [LIW-1:0] li_m1, lj_m1;

    logic [ZCW-1:0] zc;
    logic [ZCW-1:0] zc_m1;
    logic [ZIW-1:0] zc_last;
    logic [LCW-1:0] lc;
    logic           loc_bad, bad_final;
    logic           i_last, j_last;
    logic           pipe_busy, done_load;
    logic [qac_pkg::COST_W:0] acc_sum;

    // ---------------------------------------------------------------- input decode
    assign act        = qac_pkg::action_t'(action);
    assign in_stall   = (state_reg != qac_pkg::ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign eval_start = in_acc && (act == qac_pkg::ACT_EVAL);

    assign row_ok_z = RNGW'(row) < RNGW'(MAX_ZONES);
    assign col_ok_z = RNGW'(col) < RNGW'(MAX_ZONES);
    assign row_ok_l = RNGW'(row) < RNGW'(MAX_LOCATIONS);
    assign col_ok_l = RNGW'(col) < RNGW'(MAX_LOCATIONS);

    assign flow_we = in_acc && (act == qac_pkg::ACT_FLOW) && row_ok_z && col_ok_z;
    assign dist_we = in_acc && (act == qac_pkg::ACT_DIST) && row_ok_l && col_ok_l;
    assign loc_we  = in_acc && (act == qac_pkg::ACT_LOC) && row_ok_z;

    assign flow_waddr = FAW'(FAW'(row) * FAW'(MAX_ZONES) + FAW'(col));
    assign dist_waddr = DAW'(DAW'(row) * DAW'(MAX_LOCATIONS) + DAW'(col));
    assign loc_waddr  = ZIW'(row);
    // large location numbers saturate one above the maximum, which stays invalid
    assign loc_wdata  = (VALW'(value) > VALW'(MAX_LOCATIONS + 1))
                        ? LW'(MAX_LOCATIONS + 1) : LW'(value);

    // ---------------------------------------------------------------- counts
    assign zc = (ZCMPW'(zone_count_reg) > ZCMPW'(MAX_ZONES))
                ? ZCW'(MAX_ZONES) : ZCW'(zone_count_reg);
    assign lc = (LCMPW'(location_count_reg) > LCMPW'(MAX_LOCATIONS))
                ? LCW'(MAX_LOCATIONS) : LCW'(location_count_reg);
    assign zc_m1   = zc - ZCW'(1);
    assign zc_last = zc_m1[ZIW-1:0];

    assign i_last = (i_reg == zc_last);
    assign j_last = (j_reg == zc_last);

    // ---------------------------------------------------------------- memories
    assign flow_raddr = FAW'(FAW'(i_reg) * FAW'(MAX_ZONES) + FAW'(j_reg));

    // locations are 1-based and already checked valid before the sum pass
    assign li_m1      = LIW'(loca_rdata - LW'(1));
    assign lj_m1      = LIW'(locb_rdata - LW'(1));
    assign dist_raddr = DAW'(DAW'(li_m1) * DAW'(MAX_LOCATIONS) + DAW'(lj_m1));

    qac_ram #(.WIDTH(qac_pkg::DATA_W), .DEPTH(MAX_ZONES * MAX_ZONES)) u_flow_ram (
        .clk   (clk),
        .we    (flow_we),
        .waddr (flow_waddr),
        .wdata (value),
        .raddr (flow_raddr),
        .rdata (flow_rdata)
    );

    qac_ram #(.WIDTH(qac_pkg::DATA_W), .DEPTH(MAX_LOCATIONS * MAX_LOCATIONS)) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (value),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    // two copies of the mapping so loc(i) and loc(j) come out in the same cycle
    qac_ram #(.WIDTH(LW), .DEPTH(MAX_ZONES)) u_loc_a_ram (
        .clk   (clk),
        .we    (loc_we),
        .waddr (loc_waddr),
        .wdata (loc_wdata),
        .raddr (i_reg),
        .rdata (loca_rdata)
    );

    qac_ram #(.WIDTH(LW), .DEPTH(MAX_ZONES)) u_loc_b_ram (
        .clk   (clk),
        .we    (loc_we),
        .waddr (loc_waddr),
        .wdata (loc_wdata),
        .raddr (j_reg),
        .rdata (locb_rdata)
    );

    // ---------------------------------------------------------------- check logic
    assign loc_bad   = (loca_rdata == LW'(0)) || (loca_rdata > LW'(lc));
    assign bad_final = bad_reg || (p_reg && loc_bad);
    assign pipe_busy = s1_v_reg || s2_v_reg || s3_v_reg;
    assign done_load = !out_valid_reg || !out_stall;

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qac_pkg::ST_IDLE:
            begin
                if (eval_start)
                begin
                    state_next = (zc == ZCW'(0)) ? qac_pkg::ST_DONE : qac_pkg::ST_CHECK;
                end
            end
            qac_pkg::ST_CHECK:
            begin
                if (i_last)
                begin
                    state_next = qac_pkg::ST_CHECK_WAIT;
                end
            end
            qac_pkg::ST_CHECK_WAIT:
            begin
                state_next = bad_final ? qac_pkg::ST_DONE : qac_pkg::ST_SUM;
            end
            qac_pkg::ST_SUM:
            begin
                if (i_last && j_last)
                begin
                    state_next = qac_pkg::ST_DRAIN;
                end
            end
            qac_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = qac_pkg::ST_DONE;
                end
            end
            qac_pkg::ST_DONE:
            begin
                if (done_load)
                begin
                    state_next = qac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qac_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- counters
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        unique case (state_reg)
            qac_pkg::ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
            end
            qac_pkg::ST_CHECK:
            begin
                i_next = i_last ? '0 : i_reg + ZIW'(1);
            end
            qac_pkg::ST_CHECK_WAIT:
            begin
                i_next = '0;
                j_next = '0;
            end
            qac_pkg::ST_SUM:
            begin
                j_next = j_last ? '0 : j_reg + ZIW'(1);
                i_next = j_last ? i_reg + ZIW'(1) : i_reg;
            end
            qac_pkg::ST_DRAIN, qac_pkg::ST_DONE:
            begin
                i_next = i_reg;
                j_next = j_reg;
            end
            default:
            begin
                i_next = '0;
                j_next = '0;
            end
        endcase
    end

    // saturating accumulate; the running sum never exceeds COST_MAX
    assign acc_sum = {1'b0, acc_reg} + (qac_pkg::COST_W + 1)'(prod_reg);

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= qac_pkg::ST_IDLE;
            i_reg              <= '0;
            j_reg              <= '0;
            p_reg              <= 1'b0;
            bad_reg            <= 1'b0;
            s1_v_reg           <= 1'b0;
            s2_v_reg           <= 1'b0;
            s3_v_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
            zone_count_reg     <= qac_pkg::COUNT_W'(1);
            location_count_reg <= qac_pkg::COUNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= (state_reg == qac_pkg::ST_CHECK);
            s1_v_reg  <= (state_reg == qac_pkg::ST_SUM);
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;

            if (eval_start)
            begin
                bad_reg <= 1'b0;
            end
            else if (p_reg)
            begin
                bad_reg <= bad_final;
            end

            if ((state_reg == qac_pkg::ST_DONE) && done_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == qac_pkg::CFG_ZONE_COUNT)
                begin
                    zone_count_reg <= cfg_data;
                end
                else if (cfg_index == qac_pkg::CFG_LOCATION_COUNT)
                begin
                    location_count_reg <= cfg_data;
                end
            end
        end
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            f_reg <= flow_rdata;
        end
        if (s2_v_reg)
        begin
            prod_reg <= f_reg * dist_rdata;
        end
        if (eval_start)
        begin
            acc_reg <= '0;
        end
        else if (s3_v_reg)
        begin
            acc_reg <= acc_sum[qac_pkg::COST_W] ? qac_pkg::COST_MAX
                                                 : acc_sum[qac_pkg::COST_W-1:0];
        end
        if ((state_reg == qac_pkg::ST_DONE) && done_load)
        begin
            cost_reg    <= bad_reg ? '0 : acc_reg;
            bad_out_reg <= bad_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cost        = cost_reg;
    assign bad_mapping = bad_out_reg;
    assign cfg_ready   = 1'b1;

    // ---------------------------------------------------------------- assertions
    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == qac_pkg::ST_DONE)
        else $error("result posted outside the done state");

    a_bad_zero_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_out_reg) |-> (cost_reg == '0))
        else $error("bad mapping result carries a nonzero cost");

    a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qac_pkg::ST_DONE) |-> !pipe_busy)
        else $error("multiply pipeline still busy when result is posted");

    a_no_sum_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qac_pkg::ST_SUM) |-> !bad_reg)
        else $error("sum pass entered with a bad mapping");

endmodule

>>> dv/qac_checker.sv
`timescale 1ns / 100ps
// Checker for the quadratic assignment cost evaluator. It mirrors the stores and count
// registers from the observed transactions, predicts each evaluate result and compares.
// Depends on qac_pkg.
module qac_checker #(
    parameter int unsigned MAX_ZONES     = 64,
    parameter int unsigned MAX_LOCATIONS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [1:0]                  action,
    input  logic [qac_pkg::IDX_W-1:0]   row,
    input  logic [qac_pkg::IDX_W-1:0]   col,
    input  logic [qac_pkg::DATA_W-1:0]  value,

    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [qac_pkg::COST_W-1:0]  cost,
    input  logic                        bad_mapping,

    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [qac_pkg::COUNT_W-1:0] cfg_data,

    output int                          fail_count,
    output int                          results_owed
);

    typedef struct packed {
        logic [qac_pkg::COST_W-1:0] cost;
        logic                       bad_mapping;
    } cost_result_t;

    logic [qac_pkg::DATA_W-1:0]  flow_mem [MAX_ZONES*MAX_ZONES];
    logic [qac_pkg::DATA_W-1:0]  dist_mem [MAX_LOCATIONS*MAX_LOCATIONS];
    int unsigned                 zone_loc [MAX_ZONES];
    logic [qac_pkg::COUNT_W-1:0] zones_cfg;
    logic [qac_pkg::COUNT_W-1:0] locs_cfg;
    cost_result_t                cost_owed_q[$];
    cost_result_t                want;
    cost_result_t                predicted;

    // Direct gather: flow[i][j] * distance[loc(i)-1][loc(j)-1] over zones in use.
    function automatic cost_result_t assignment_cost();
        int unsigned  zc;
        int unsigned  lc;
        int unsigned  li;
        int unsigned  lj;
        int unsigned  i;
        int unsigned  j;
        logic [63:0]  acc;
        logic [63:0]  term;
        cost_result_t res;
        zc = (zones_cfg > MAX_ZONES) ? MAX_ZONES : zones_cfg;
        lc = (locs_cfg > MAX_LOCATIONS) ? MAX_LOCATIONS : locs_cfg;
        res.bad_mapping = 1'b0;
        for (i = 0; i < zc; i++)
            if (zone_loc[i] == 0 || zone_loc[i] > lc)
                res.bad_mapping = 1'b1;
        acc = '0;
        if (!res.bad_mapping)
        begin
            for (i = 0; i < zc; i++)
            begin
                li = zone_loc[i] - 1;
                for (j = 0; j < zc; j++)
                begin
                    lj = zone_loc[j] - 1;
                    term = 64'(flow_mem[i*MAX_ZONES + j]) *
                           64'(dist_mem[li*MAX_LOCATIONS + lj]);
                    acc += term;
                    if (acc > 64'(qac_pkg::COST_MAX))
                        acc = 64'(qac_pkg::COST_MAX);
                end
            end
        end
        res.cost = res.bad_mapping ? '0 : acc[qac_pkg::COST_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zones_cfg = 7'd1;
            locs_cfg  = 7'd1;
            cost_owed_q.delete();
            results_owed = 0;
            fail_count   = 0;
        end
        else
        begin
            // results are retired before a same-edge evaluate is queued
            if (out_valid && !out_stall)
            begin
                if (cost_owed_q.size() == 0)
                begin
                    $error("result with no evaluate outstanding: cost %0d bad_mapping %0b",
                           cost, bad_mapping);
                    fail_count++;
                end
                else
                begin
                    want = cost_owed_q.pop_front();
                    if (cost !== want.cost)
                    begin
                        $error("cost: expected %0d, got %0d", want.cost, cost);
                        fail_count++;
                    end
                    if (bad_mapping !== want.bad_mapping)
                    begin
                        $error("bad_mapping: expected %0b, got %0b",
                               want.bad_mapping, bad_mapping);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    qac_pkg::CFG_ZONE_COUNT:     zones_cfg = cfg_data;
                    qac_pkg::CFG_LOCATION_COUNT: locs_cfg  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                case (qac_pkg::action_t'(action))
                    qac_pkg::ACT_FLOW:
                        if (row < MAX_ZONES && col < MAX_ZONES)
                            flow_mem[row*MAX_ZONES + col] = value;
                    qac_pkg::ACT_DIST:
                        if (row < MAX_LOCATIONS && col < MAX_LOCATIONS)
                            dist_mem[row*MAX_LOCATIONS + col] = value;
                    qac_pkg::ACT_LOC:
                        if (row < MAX_ZONES)
                            zone_loc[row] = (value > MAX_LOCATIONS + 1) ?
                                            MAX_LOCATIONS + 1 : value;
                    qac_pkg::ACT_EVAL:
                    begin
                        predicted   = assignment_cost();
                        cost_owed_q = {cost_owed_q, predicted};
                    end
                    default: ;
                endcase
            end
            results_owed = cost_owed_q.size();
        end
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the quadratic assignment cost evaluator: clock, reset, stimulus,
// output back-pressure and the verdict. Depends on qac_pkg, quadratic_assignment_cost
// and qac_checker.
module tb_top;

    localparam int unsigned ZONES        = 64;
    localparam int unsigned LOCS         = 64;
    localparam int          RANDOM_ITEMS = 60;
    localparam logic [qac_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // decodes to no register

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        in_valid    = 1'b0;
    logic                        in_stall;
    logic [1:0]                  action      = qac_pkg::ACT_FLOW;
    logic [qac_pkg::IDX_W-1:0]   row         = '0;
    logic [qac_pkg::IDX_W-1:0]   col         = '0;
    logic [qac_pkg::DATA_W-1:0]  value       = '0;
    logic                        out_valid;
    logic                        out_stall   = 1'b0;
    logic [qac_pkg::COST_W-1:0]  cost;
    logic                        bad_mapping;
    logic                        cfg_valid   = 1'b0;
    logic                        cfg_ready;
    logic [1:0]                  cfg_index   = qac_pkg::CFG_ZONE_COUNT;
    logic [qac_pkg::COUNT_W-1:0] cfg_data    = '0;

    int fails;
    int owed;
    int snd_idle = 22;
    int rcv_idle = 80;
    int items_sent = 0;

    // what has been written so far, so that no unwritten entry is ever read
    bit          flow_set [ZONES*ZONES];
    bit          dist_set [LOCS*LOCS];
    bit          loc_set  [ZONES];
    int unsigned loc_seen [ZONES];
    int unsigned zones_now = 1;
    int unsigned locs_now  = 1;

    quadratic_assignment_cost #(
        .MAX_ZONES     (ZONES),
        .MAX_LOCATIONS (LOCS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .row         (row),
        .col         (col),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cost        (cost),
        .bad_mapping (bad_mapping),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    qac_checker #(
        .MAX_ZONES     (ZONES),
        .MAX_LOCATIONS (LOCS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .row          (row),
        .col          (col),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cost         (cost),
        .bad_mapping  (bad_mapping),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fails),
        .results_owed (owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < rcv_idle);

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [qac_pkg::DATA_W-1:0] rand_entry();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return qac_pkg::DATA_W'($urandom);
        endcase
    endfunction

    // one input transaction; valid stays high afterwards until the next negedge
    task automatic send_item(input qac_pkg::action_t act,
                             input logic [qac_pkg::IDX_W-1:0] r,
                             input logic [qac_pkg::IDX_W-1:0] c,
                             input logic [qac_pkg::DATA_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        action   = act;
        row      = r;
        col      = c;
        value    = v;
        do @(posedge clk); while (in_stall);
        items_sent++;
        case (act)
            qac_pkg::ACT_FLOW: flow_set[r*ZONES + c] = 1'b1;
            qac_pkg::ACT_DIST: dist_set[r*LOCS + c]  = 1'b1;
            qac_pkg::ACT_LOC:
            begin
                loc_set[r]  = 1'b1;
                loc_seen[r] = (v > LOCS + 1) ? LOCS + 1 : v;
            end
            default: ;
        endcase
    endtask

    // drop valid, wait out every outstanding result, then idle with no input
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (owed != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [qac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qac_pkg::COUNT_W-1:0] d);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            qac_pkg::CFG_ZONE_COUNT:     zones_now = d;
            qac_pkg::CFG_LOCATION_COUNT: locs_now  = d;
            default: ;
        endcase
    endtask

    task automatic reconfigure(input logic [qac_pkg::COUNT_W-1:0] z,
                               input logic [qac_pkg::COUNT_W-1:0] l);
        settle();
        write_reg(qac_pkg::CFG_ZONE_COUNT, z);
        write_reg(qac_pkg::CFG_LOCATION_COUNT, l);
    endtask

    // Fill whatever the evaluate will read, then issue it. With repair set, bad
    // mapping entries of zones in use are rewritten to valid locations first.
    task automatic evaluate_legal(input bit repair);
        int unsigned zc;
        int unsigned lc;
        int unsigned i;
        int unsigned j;
        int unsigned li;
        int unsigned lj;
        bit          bad;
        zc = (zones_now > ZONES) ? ZONES : zones_now;
        lc = (locs_now > LOCS) ? LOCS : locs_now;
        for (i = 0; i < zc; i++)
        begin
            if (!loc_set[i])
                send_item(qac_pkg::ACT_LOC, qac_pkg::IDX_W'(i), qac_pkg::IDX_W'($urandom),
                          (lc == 0) ? qac_pkg::DATA_W'($urandom)
                                    : qac_pkg::DATA_W'($urandom_range(1, lc)));
            else if (repair && lc != 0 && (loc_seen[i] == 0 || loc_seen[i] > lc))
                send_item(qac_pkg::ACT_LOC, qac_pkg::IDX_W'(i), qac_pkg::IDX_W'($urandom),
                          qac_pkg::DATA_W'($urandom_range(1, lc)));
        end
        bad = 1'b0;
        for (i = 0; i < zc; i++)
            if (loc_seen[i] == 0 || loc_seen[i] > lc)
                bad = 1'b1;
        if (!bad)
        begin
            for (i = 0; i < zc; i++)
            begin
                for (j = 0; j < zc; j++)
                begin
                    li = loc_seen[i] - 1;
                    lj = loc_seen[j] - 1;
                    if (!flow_set[i*ZONES + j])
                        send_item(qac_pkg::ACT_FLOW, qac_pkg::IDX_W'(i), qac_pkg::IDX_W'(j),
                                  rand_entry());
                    if (!dist_set[li*LOCS + lj])
                        send_item(qac_pkg::ACT_DIST, qac_pkg::IDX_W'(li), qac_pkg::IDX_W'(lj),
                                  rand_entry());
                end
            end
        end
        send_item(qac_pkg::ACT_EVAL, qac_pkg::IDX_W'($urandom), qac_pkg::IDX_W'($urandom),
                  qac_pkg::DATA_W'($urandom));
    endtask

    // a single write that lands inside the zones and locations in use
    task automatic write_in_use();
        int unsigned zc;
        int unsigned lc;
        zc = (zones_now > ZONES) ? ZONES : zones_now;
        lc = (locs_now > LOCS) ? LOCS : locs_now;
        case ($urandom_range(0, 2))
            0: if (zc != 0)
                send_item(qac_pkg::ACT_FLOW, qac_pkg::IDX_W'($urandom_range(0, zc - 1)),
                          qac_pkg::IDX_W'($urandom_range(0, zc - 1)), rand_entry());
            1: if (lc != 0)
                send_item(qac_pkg::ACT_DIST, qac_pkg::IDX_W'($urandom_range(0, lc - 1)),
                          qac_pkg::IDX_W'($urandom_range(0, lc - 1)), rand_entry());
            default: if (zc != 0 && lc != 0)
                send_item(qac_pkg::ACT_LOC, qac_pkg::IDX_W'($urandom_range(0, zc - 1)),
                          qac_pkg::IDX_W'($urandom),
                          qac_pkg::DATA_W'($urandom_range(1, lc)));
        endcase
    endtask

    initial
    begin
        int          base;
        int          done_items;
        int          next_cfg;
        int unsigned zc;
        int unsigned lc;
        int unsigned i;
        logic [qac_pkg::COUNT_W-1:0] z_pick;
        logic [qac_pkg::COUNT_W-1:0] l_pick;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // counts at their reset value of one: largest single product
        send_item(qac_pkg::ACT_LOC, 6'd0, 6'd0, 16'd1);
        send_item(qac_pkg::ACT_FLOW, 6'd0, 6'd0, 16'hFFFF);
        send_item(qac_pkg::ACT_DIST, 6'd0, 6'd0, 16'hFFFF);
        send_item(qac_pkg::ACT_EVAL, 6'h3F, 6'h3F, 16'hFFFF);
        // location zero
        send_item(qac_pkg::ACT_LOC, 6'd0, 6'd0, 16'd0);
        send_item(qac_pkg::ACT_EVAL, 6'd0, 6'd0, 16'd0);
        // huge location number, kept saturated and invalid
        send_item(qac_pkg::ACT_LOC, 6'd0, 6'h3F, 16'hFFFF);
        send_item(qac_pkg::ACT_EVAL, 6'd0, 6'd0, 16'd0);
        // location just above the count
        send_item(qac_pkg::ACT_LOC, 6'd0, 6'd0, 16'd2);
        send_item(qac_pkg::ACT_EVAL, 6'd0, 6'd0, 16'd0);

        // no zones: zero cost, no error
        reconfigure(7'd0, 7'd1);
        send_item(qac_pkg::ACT_EVAL, 6'd0, 6'd0, 16'd0);
        // no locations: every mapping invalid
        reconfigure(7'd1, 7'd0);
        send_item(qac_pkg::ACT_LOC, 6'd0, 6'd0, 16'd1);
        send_item(qac_pkg::ACT_EVAL, 6'd0, 6'd0, 16'd0);

        // location count above the maximum acts as the maximum
        reconfigure(7'd1, 7'h7F);
        send_item(qac_pkg::ACT_LOC, 6'd0, 6'd0, qac_pkg::DATA_W'(LOCS));
        send_item(qac_pkg::ACT_DIST, 6'd63, 6'd63, 16'hFFFF);
        send_item(qac_pkg::ACT_EVAL, 6'd0, 6'd0, 16'd0);
        send_item(qac_pkg::ACT_LOC, 6'd0, 6'd0, 16'hFFFF);
        send_item(qac_pkg::ACT_EVAL, 6'd0, 6'd0, 16'd0);

        // zone count above the maximum: the last zone in use points past the locations
        reconfigure(7'h7F, 7'h7F);
        for (i = 0; i < ZONES; i++)
            send_item(qac_pkg::ACT_LOC, qac_pkg::IDX_W'(i), 6'd0,
                      (i == ZONES - 1) ? qac_pkg::DATA_W'(LOCS + 1)
                                       : qac_pkg::DATA_W'(i + 1));
        send_item(qac_pkg::ACT_EVAL, 6'd0, 6'd0, 16'd0);

        // write to an unused register index must leave both counts alone
        reconfigure(7'd2, 7'd3);
        write_reg(CFG_SPARE, 7'h55);
        evaluate_legal(1'b1);

        base     = items_sent;
        next_cfg = 0;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            done_items = items_sent - base;
            if (done_items < RANDOM_ITEMS / 3)
            begin
                snd_idle = 22;
                rcv_idle = 80;
            end
            else if (done_items < 2 * RANDOM_ITEMS / 3)
            begin
                snd_idle = 80;
                rcv_idle = 22;
            end
            else
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end

            if (done_items >= next_cfg)
            begin
                z_pick = ($urandom_range(0, 9) == 0) ? 7'd0
                                                      : qac_pkg::COUNT_W'($urandom_range(1, 4));
                case ($urandom_range(0, 9))
                    0:       l_pick = 7'd0;
                    1:       l_pick = 7'h7F;
                    default: l_pick = qac_pkg::COUNT_W'($urandom_range(1, 10));
                endcase
                reconfigure(z_pick, l_pick);
                next_cfg += 15;
            end

            zc = (zones_now > ZONES) ? ZONES : zones_now;
            lc = (locs_now > LOCS) ? LOCS : locs_now;
            case ($urandom_range(0, 19))
                0, 1, 2:
                    // noise: any store, any position, any value
                    send_item(qac_pkg::action_t'($urandom_range(0, 2)),
                              qac_pkg::IDX_W'($urandom), qac_pkg::IDX_W'($urandom),
                              qac_pkg::DATA_W'($urandom));
                3, 4, 5:
                begin
                    // break one zone's mapping, then evaluate as it stands
                    if (zc != 0)
                        send_item(qac_pkg::ACT_LOC, qac_pkg::IDX_W'($urandom_range(0, zc - 1)),
                                  qac_pkg::IDX_W'($urandom),
                                  ($urandom_range(0, 1) != 0) ? 16'd0 :
                                  qac_pkg::DATA_W'($urandom_range(lc + 1, 65535)));
                    evaluate_legal(1'b0);
                end
                default:
                begin
                    repeat ($urandom_range(0, 3)) write_in_use();
                    evaluate_legal(1'b1);
                end
            endcase
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (owed != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
